// ===== hdl/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int ByteW  = 8;
    localparam int CpW    = 21;
    localparam int PendW  = 2;
    localparam int TdataW = ((CpW + 7) / 8) * 8;

    localparam logic [CpW-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CpW-1:0] SURR_LOW       = 21'h00D800;
    localparam logic [CpW-1:0] SURR_HIGH      = 21'h00DFFF;
    localparam logic [ByteW-1:0] LEAD4_MAX    = 8'hF4;

    // Sequence state carried between bytes
    typedef struct packed {
        logic [PendW-1:0] pending;
        logic [CpW-1:0]   partial;
    } dec_state_t;

    // Decode result for one byte
    typedef struct packed {
        logic           emit;
        logic [CpW-1:0] code_point;
        logic           replaced;
    } dec_result_t;

endpackage

// ===== hdl/utf8sd_decode.sv =====
// ----------------------------------------------------------------------------
// utf8sd_decode
// One-byte decode step: next sequence state and optional code point.
// ----------------------------------------------------------------------------
module utf8sd_decode
(
    input  logic [utf8sd_pkg::ByteW-1:0] in_byte,
    input  utf8sd_pkg::dec_state_t       state,
    output utf8sd_pkg::dec_state_t       state_next,
    output utf8sd_pkg::dec_result_t      result
);

    logic                        raw_emit;
    logic [utf8sd_pkg::CpW-1:0]  raw_cp;
    logic                        raw_repl;
    logic [utf8sd_pkg::CpW-1:0]  shifted;
    logic                        is_surr;

    assign shifted = {state.partial[utf8sd_pkg::CpW-7:0], in_byte[5:0]};

    always_comb
    begin
        state_next = state;
        raw_emit   = 1'b0;
        raw_cp     = '0;
        raw_repl   = 1'b0;
        if (state.pending != '0)
        begin
            // continuation byte, top bits unchecked
            state_next.partial = shifted;
            state_next.pending = state.pending - 2'd1;
            raw_emit           = (state.pending == 2'd1);
            raw_cp             = shifted;
        end
        else if (in_byte[7] == 1'b0)
        begin
            raw_emit = 1'b1;
            raw_cp   = {{(utf8sd_pkg::CpW-utf8sd_pkg::ByteW){1'b0}}, in_byte};
        end
        else if (in_byte[7:5] == 3'b110)
        begin
            state_next.partial = {{(utf8sd_pkg::CpW-5){1'b0}}, in_byte[4:0]};
            state_next.pending = 2'd1;
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            state_next.partial = {{(utf8sd_pkg::CpW-4){1'b0}}, in_byte[3:0]};
            state_next.pending = 2'd2;
        end
        else if (in_byte[7:3] == 5'b11110 && in_byte <= utf8sd_pkg::LEAD4_MAX)
        begin
            state_next.partial = {{(utf8sd_pkg::CpW-3){1'b0}}, in_byte[2:0]};
            state_next.pending = 2'd3;
        end
        else
        begin
            // stray continuation or invalid lead
            raw_emit = 1'b1;
            raw_cp   = utf8sd_pkg::CP_REPLACEMENT;
            raw_repl = 1'b1;
        end
    end

    assign is_surr = (raw_cp >= utf8sd_pkg::SURR_LOW) && (raw_cp <= utf8sd_pkg::SURR_HIGH);

    always_comb
    begin
        result.emit       = raw_emit;
        result.code_point = is_surr ? utf8sd_pkg::CP_REPLACEMENT : raw_cp;
        result.replaced   = raw_repl | is_surr;
    end

endmodule

// ===== hdl/utf8_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Byte-serial UTF-8 decoder, one byte per cycle unless the output stalls, one code point per sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) takes one raw stream byte per word in s_tdata[7:0].
//   Master channel (m_*) gives one decoded code point per word:
//     m_tdata[20:0] code point, m_tuser = 1 when it is U+FFFD standing in
//     for a bad lead byte or a surrogate value.
//   Bytes that open or extend a sequence produce no output word.
//   Throughput: one byte per cycle sustained unless an emitting byte is
//   blocked by the output; the only loop is the sequence state (pending
//   count and partial value), updated by a shift, mask and OR.
//   Pipeline: two register stages. An accepted byte sits in the input
//   register; its code point moves to the output register once that is free.
//   Stall: while m_tready is low the output word holds; the input register
//   still drains bytes that produce no output, and s_tready drops only when
//   a byte that completes a code point finds the output register full.
//   Reset (rst_n low, async): both stages empty, no sequence open.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [utf8sd_pkg::ByteW-1:0]      s_tdata,   // [7:0] in_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [utf8sd_pkg::TdataW-1:0]     m_tdata,   // [20:0] code_point, rest zero
    output logic                              m_tuser    // [0] replaced
);

    // input stage
    logic                           byte_valid_reg;
    logic [utf8sd_pkg::ByteW-1:0]   byte_reg;

    // sequence state
    utf8sd_pkg::dec_state_t         state_reg;
    utf8sd_pkg::dec_state_t         state_next;
    utf8sd_pkg::dec_result_t        result;

    // output stage
    logic                           out_valid_reg;
    logic [utf8sd_pkg::CpW-1:0]     out_cp_reg;
    logic                           out_repl_reg;

    logic                           out_free;
    logic                           advance;
    logic                           s_accept;

    utf8sd_decode u_decode
    (
        .in_byte    (byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // output slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    // input byte retires unless it emits into a blocked output
    assign advance  = byte_valid_reg && (!result.emit || out_free);
    assign s_tready = !byte_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            byte_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            out_cp_reg   <= result.code_point;
            out_repl_reg <= result.replaced;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(utf8sd_pkg::TdataW-utf8sd_pkg::CpW){1'b0}}, out_cp_reg};
    assign m_tuser  = out_repl_reg;

`ifndef NO_ASSERTIONS
    // a flagged word always carries the replacement character
    a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[20:0] == utf8sd_pkg::CP_REPLACEMENT))
        else $error("replaced word without U+FFFD");

    // no surrogate value leaves unflagged
    a_no_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
            ((m_tdata[20:0] < utf8sd_pkg::SURR_LOW) || (m_tdata[20:0] > utf8sd_pkg::SURR_HIGH)))
        else $error("surrogate code point emitted");

    // a freshly opened four-byte sequence holds only three payload bits
    a_lead4_width: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pending == 2'd3) |-> (state_reg.partial[20:3] == '0))
        else $error("partial value too wide for four-byte lead");

    // a stalled output word that is not taken stays pending
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output word dropped under stall");
`endif

endmodule
